/* hw/rtl/kclru_pkg.sv */
// shared types and constants for the keyed cache lru tag table
package kclru_pkg;

    // request command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // field widths
    localparam int KEY_W = 64;
    localparam int AGE_W = 16;
    localparam int OUT_IDX_W = 4;

    // age given to a touched entry
    localparam logic [AGE_W-1:0] TOUCH_AGE = 16'd8192;

    // update command broadcast to every cell
    typedef struct packed {
        logic touch;
        logic insert;
    } kclru_ctl_t;

endpackage

/* hw/rtl/kclru_cell.sv */
// one tag table entry with its slice of the lookup and victim search chain
module kclru_cell #(
    parameter int IW = 4,
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kclru_pkg::KEY_W-1:0]   q_key,
    input  kclru_pkg::kclru_ctl_t         ctl,
    input  logic                          sel,
    input  logic                          in_found,
    input  logic [IW-1:0]                 in_match_idx,
    input  logic                          in_empty_found,
    input  logic [IW-1:0]                 in_empty_idx,
    input  logic                          in_best_valid,
    input  logic [kclru_pkg::AGE_W-1:0]   in_best_age,
    input  logic [IW-1:0]                 in_best_idx,
    output logic                          out_found,
    output logic [IW-1:0]                 out_match_idx,
    output logic                          out_empty_found,
    output logic [IW-1:0]                 out_empty_idx,
    output logic                          out_best_valid,
    output logic [kclru_pkg::AGE_W-1:0]   out_best_age,
    output logic [IW-1:0]                 out_best_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [kclru_pkg::KEY_W-1:0] key_reg;
    logic                        occ_reg;
    logic [kclru_pkg::AGE_W-1:0] age_reg;

    logic                        found_reg;
    logic [IW-1:0]               match_idx_reg;
    logic                        empty_found_reg;
    logic [IW-1:0]               empty_idx_reg;
    logic                        best_valid_reg;
    logic [kclru_pkg::AGE_W-1:0] best_age_reg;
    logic [IW-1:0]               best_idx_reg;

    logic hit_here;
    logic take_best;

    // local compare against the request key and the running minimum
    assign hit_here  = occ_reg && (key_reg == q_key);
    assign take_best = !in_best_valid || (age_reg < in_best_age);

    // entry state: occupancy set on insert, age update on every touch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            age_reg <= '0;
        end
        else if (ctl.touch)
        begin
            if (sel)
            begin
                age_reg <= kclru_pkg::TOUCH_AGE;
                if (ctl.insert)
                begin
                    occ_reg <= 1'b1;
                end
            end
            else if (occ_reg && (age_reg != '0))
            begin
                age_reg <= age_reg - 1'b1;
            end
        end
    end

    // key storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.touch && ctl.insert && sel)
        begin
            key_reg <= q_key;
        end
    end

    // search record handed to the next cell
    always_ff @(posedge clk)
    begin
        found_reg       <= in_found || hit_here;
        match_idx_reg   <= in_found ? in_match_idx : MY_IDX;
        empty_found_reg <= in_empty_found || !occ_reg;
        empty_idx_reg   <= in_empty_found ? in_empty_idx : MY_IDX;
        best_valid_reg  <= 1'b1;
        best_age_reg    <= take_best ? age_reg : in_best_age;
        best_idx_reg    <= take_best ? MY_IDX : in_best_idx;
    end

    assign out_found       = found_reg;
    assign out_match_idx   = match_idx_reg;
    assign out_empty_found = empty_found_reg;
    assign out_empty_idx   = empty_idx_reg;
    assign out_best_valid  = best_valid_reg;
    assign out_best_age    = best_age_reg;
    assign out_best_idx    = best_idx_reg;

endmodule

/* hw/rtl/keyed_cache_lru_replacement_unit.sv */
// top level of the keyed cache tag table with counter-based lru replacement
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | cmd, key
//   rsp     | out       | rsp_valid, rsp_stall | hit, entry_index
//
// a request is captured, the search record then ripples down the chain of
// cells, and a final step applies the touch and loads the response
// register.
// a stalled response holds the block in its final step; a new request is
// taken while an earlier response still waits.
// reset empties every entry at once, no clearing pass is needed.
module keyed_cache_lru_replacement_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                cmd,
    input  logic [kclru_pkg::KEY_W-1:0]         key,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                hit,
    output logic [kclru_pkg::OUT_IDX_W-1:0]     entry_index
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int XW = (IW > kclru_pkg::OUT_IDX_W) ? IW : kclru_pkg::OUT_IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [IW-1:0]               cnt_reg;
    logic                        q_cmd_reg;
    logic [kclru_pkg::KEY_W-1:0] q_key_reg;
    logic                        rsp_valid_reg;
    logic                        hit_reg;
    logic [kclru_pkg::OUT_IDX_W-1:0] idx_reg;

    // search chain links, link 0 is the empty starting record
    logic                        found_w       [ENTRIES+1];
    logic [IW-1:0]               match_idx_w   [ENTRIES+1];
    logic                        empty_found_w [ENTRIES+1];
    logic [IW-1:0]               empty_idx_w   [ENTRIES+1];
    logic                        best_valid_w  [ENTRIES+1];
    logic [kclru_pkg::AGE_W-1:0] best_age_w    [ENTRIES+1];
    logic [IW-1:0]               best_idx_w    [ENTRIES+1];

    kclru_pkg::kclru_ctl_t       ctl;
    logic [IW-1:0]               touch_idx;
    logic                        done_go;
    logic                        res_hit;
    logic [IW-1:0]               res_idx;
    logic [XW-1:0]               res_idx_ext;

    assign found_w[0]       = 1'b0;
    assign match_idx_w[0]   = '0;
    assign empty_found_w[0] = 1'b0;
    assign empty_idx_w[0]   = '0;
    assign best_valid_w[0]  = 1'b0;
    assign best_age_w[0]    = '0;
    assign best_idx_w[0]    = '0;

    // final step may proceed once the response register is free
    assign done_go = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    // decision from the record at the end of the chain
    always_comb
    begin
        ctl.touch  = 1'b0;
        ctl.insert = 1'b0;
        touch_idx  = '0;
        res_hit    = 1'b0;
        res_idx    = '0;
        if (q_cmd_reg == kclru_pkg::CMD_INSERT)
        begin
            touch_idx = empty_found_w[ENTRIES] ? empty_idx_w[ENTRIES]
                                               : best_idx_w[ENTRIES];
            res_idx    = touch_idx;
            ctl.touch  = done_go;
            ctl.insert = done_go;
        end
        else if (found_w[ENTRIES])
        begin
            touch_idx = match_idx_w[ENTRIES];
            res_idx   = touch_idx;
            res_hit   = 1'b1;
            ctl.touch = done_go;
        end
    end

    assign res_idx_ext = XW'(res_idx);

    // row of entry cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kclru_cell #(
            .IW    (IW),
            .INDEX (i)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .q_key           (q_key_reg),
            .ctl             (ctl),
            .sel             (touch_idx == IW'(i)),
            .in_found        (found_w[i]),
            .in_match_idx    (match_idx_w[i]),
            .in_empty_found  (empty_found_w[i]),
            .in_empty_idx    (empty_idx_w[i]),
            .in_best_valid   (best_valid_w[i]),
            .in_best_age     (best_age_w[i]),
            .in_best_idx     (best_idx_w[i]),
            .out_found       (found_w[i+1]),
            .out_match_idx   (match_idx_w[i+1]),
            .out_empty_found (empty_found_w[i+1]),
            .out_empty_idx   (empty_idx_w[i+1]),
            .out_best_valid  (best_valid_w[i+1]),
            .out_best_age    (best_age_w[i+1]),
            .out_best_idx    (best_idx_w[i+1])
        );
    end

    // sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // post on the final step, clear once the response is taken
            if (done_go)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg == IW'(ENTRIES - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (done_go)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request and response payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req_valid)
        begin
            q_cmd_reg <= cmd;
            q_key_reg <= key;
        end
        if (done_go)
        begin
            hit_reg <= res_hit;
            idx_reg <= res_idx_ext[kclru_pkg::OUT_IDX_W-1:0];
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign hit         = hit_reg;
    assign entry_index = idx_reg;

    // only an idle sequencer takes a request
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> req_stall)
        else $error("request taken while busy");

    // the final step always posts a response
    a_done_posts: assert property (@(posedge clk) disable iff (!rst_n)
        done_go |=> rsp_valid)
        else $error("final step did not post a response");

    // an insert never reports a hit
    a_insert_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done_go && (q_cmd_reg == kclru_pkg::CMD_INSERT)) |=> !hit)
        else $error("insert reported a hit");

    // the final step is reached only through a full scan
    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_DONE) |-> ($past(state_reg) == S_SCAN))
        else $error("final step entered without a scan");

endmodule
